// ===== design/plw_pkg.sv =====
`timescale 1ns / 1ps
package plw_pkg;

  // Fraction bits of the log and exponent words.
  localparam int unsigned FRAC_BITS = 16;
  // Quadratic correction of the log2 mantissa (Q0.16 coefficient).
  localparam logic [14:0] LOG_CORR = 15'd22714;
  // Quadratic correction of the exp2 mantissa (Q0.16 coefficient).
  localparam logic [13:0] EXP_CORR = 14'd11246;
  // Exponent value that means 1.0 in Q.8.
  localparam int unsigned P_ONE = 256;
  // Shifts past this point give a zero result.
  localparam int unsigned EXP_MAX_SHIFT = 44;
  // Mantissa of 1.0 in Q1.16.
  localparam logic [16:0] MANT_ONE = 17'h10000;

endpackage

// ===== design/plw_log.sv =====
`timescale 1ns / 1ps
module plw_log import plw_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int LW = 20,
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vin,
  input  logic [SAMPLE_BITS-1:0] mag,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   vout,
  output logic [LW-1:0]          neg_log,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int TOP = SAMPLE_BITS - 1;
  localparam int SHW = $clog2(SAMPLE_BITS);

  logic [2:0]            v;
  logic [SIDE_W-1:0]     side1, side2;
  logic [SHW-1:0]        sh1, sh2;
  logic [15:0]           f1, f2;
  logic [31:0]           t2;

  logic [SHW-1:0]             k;
  logic [SAMPLE_BITS-1:0]     mn;
  logic [SAMPLE_BITS+15:0]    ext;
  logic [46:0]                corr;
  logic [16:0]                lf;

  // Normalize the magnitude so its top bit lands on the sign position.
  always_comb begin
    k = '0;
    for (int b = 0; b < SAMPLE_BITS; b++) begin
      if (mag[b]) k = SHW'(b);
    end
    mn  = mag << (SHW'(TOP) - k);
    ext = {mn, 16'b0};
  end

  assign corr = 47'(LOG_CORR) * 47'(t2);
  assign lf   = 17'(f2) + 17'(corr[46:32]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side_in;
      sh1   <= SHW'(TOP) - k;
      f1    <= ext[TOP+15 -: 16];
      side2 <= side1;
      sh2   <= sh1;
      f2    <= f1;
      t2    <= 32'(33'(f1) * (33'(MANT_ONE) - 33'(f1)));
      side_out <= side2;
      neg_log  <= LW'({sh2, 16'b0}) - LW'(lf);
    end
  end

  assign vout = v[2];

endmodule

// ===== design/plw_div.sv =====
`timescale 1ns / 1ps
module plw_div #(
  parameter int QW = 28,
  parameter int EXP_BITS = 16,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vin,
  input  logic [QW-1:0]       num,
  input  logic [EXP_BITS-1:0] den,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                vout,
  output logic [QW-1:0]       quot,
  output logic [SIDE_W-1:0]   side_out
);

  // One quotient bit per stage; the numerator shifts out the top while
  // quotient bits shift in at the bottom of the same word.
  logic [QW-1:0]       v;
  logic [QW-1:0]       wq   [QW];
  logic [EXP_BITS-1:0] rem  [QW];
  logic [EXP_BITS-1:0] dd   [QW];
  logic [SIDE_W-1:0]   sd   [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[QW-2:0], vin};
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [QW-1:0]       w_in;
    logic [EXP_BITS-1:0] r_in, d_in;
    logic [SIDE_W-1:0]   s_in;
    logic [EXP_BITS:0]   trial, diff;
    logic                ge;

    if (i == 0) begin : g_first
      assign w_in = num;
      assign r_in = '0;
      assign d_in = den;
      assign s_in = side_in;
    end else begin : g_next
      assign w_in = wq[i-1];
      assign r_in = rem[i-1];
      assign d_in = dd[i-1];
      assign s_in = sd[i-1];
    end

    assign trial = {r_in, w_in[QW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        wq[i]  <= {w_in[QW-2:0], ge};
        rem[i] <= ge ? diff[EXP_BITS-1:0] : trial[EXP_BITS-1:0];
        dd[i]  <= d_in;
        sd[i]  <= s_in;
      end
    end
  end

  assign vout     = v[QW-1];
  assign quot     = wq[QW-1];
  assign side_out = sd[QW-1];

endmodule

// ===== design/plw_exp.sv =====
`timescale 1ns / 1ps
module plw_exp import plw_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int EW = 28,
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   vin,
  input  logic [EW-1:0]          e,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   vout,
  output logic [SAMPLE_BITS-1:0] r,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int NW = EW - 16;

  logic [2:0]        v;
  logic [SIDE_W-1:0] side1, side2;
  logic [NW-1:0]     n1, n2;
  logic [15:0]       u1;
  logic [32:0]       t1;
  logic [16:0]       mant2;

  logic [47:0] corr;
  logic [63:0] prod, sum;
  logic [5:0]  s;

  assign corr = 48'(EXP_CORR) * 48'(t1);
  assign prod = 64'(mant2) << (SAMPLE_BITS - 1);
  assign s    = 6'(16 + 6'(n2));
  assign sum  = (prod + (64'd1 << (s - 6'd1))) >> s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side_in;
      n1    <= e[EW-1:16];
      u1    <= e[15:0];
      t1    <= 33'(e[15:0]) * (33'(MANT_ONE) - 33'(e[15:0]));
      side2 <= side1;
      n2    <= n1;
      mant2 <= MANT_ONE - 17'(u1[15:1]) - 17'(corr[47:32]);
      side_out <= side2;
      if (n2 > NW'(EXP_MAX_SHIFT)) begin
        r <= '0;
      end else begin
        r <= sum[SAMPLE_BITS-1:0];
      end
    end
  end

  assign vout = v[2];

endmodule

// ===== design/power_law_waveshaper_top.sv =====
`timescale 1ns / 1ps
// Power-law waveshaper: each transfer carries a signed Q1.(SAMPLE_BITS-1)
// sample and an unsigned Q.8 exponent p (256 = 1.0), and yields one shaped
// sample. curve_mode 0 gives sign(x)*|x|^(1/p); curve_mode 1 gives
// sign(x)*(1-(1-|x|)^p). Minus full scale and p = 1.0 pass straight through,
// p = 0 gives 0, and a positive full-scale result saturates. Powers are
// a^e = 2^(e*log2 a) with a quadratic log2 and exp2. The block takes one
// sample per cycle while the output is not stalled. The root curve uses
// a divider that makes one quotient bit per stage, QW bits in all, with
// QW = $clog2(SAMPLE_BITS)+24. The whole pipeline holds while the output
// transfer stalls; curve_mode may be written only while the pipeline is empty.
module power_law_waveshaper_top import plw_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int EXP_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample_in [SAMPLE_BITS-1:0], exponent above it, zero padding on top
  input  logic [((SAMPLE_BITS+EXP_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // sample_out [SAMPLE_BITS-1:0], zero padding on top
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int SB   = SAMPLE_BITS;
  localparam int EB   = EXP_BITS;
  localparam int OW   = ((SB + 7) / 8) * 8;
  localparam int LW   = $clog2(SB) + 16;
  localparam int QW   = LW + 8;
  localparam int MW   = LW + EB;
  localparam int EW   = (EB > 16) ? (LW + EB - 8) : QW;
  // Flags that ride along: neg, byp, zero, mode, then the raw sample.
  localparam int SIDE = SB + 4;

  localparam logic [SB-1:0] FS = SB'(1) << (SB - 1);

  logic curve_mode;
  logic en;

  // Whole pipeline advances when the output register is free or draining.
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= 1'b0;
    end else if (cfg_we) begin
      curve_mode <= cfg_data;
    end
  end

  // Stage A: unpack, take the magnitude, flag the special cases.
  logic signed [SB-1:0] x_in;
  logic [EB-1:0]        p_in;
  logic [SB-1:0]        ax_in;
  logic                 neg_in, byp_in, zero_in;

  assign x_in    = s_axis_tdata[SB-1:0];
  assign p_in    = s_axis_tdata[SB+EB-1:SB];
  assign neg_in  = x_in[SB-1];
  assign ax_in   = neg_in ? SB'(-x_in) : SB'(x_in);
  // Compare p wide enough that a narrow exponent never aliases 1.0.
  assign byp_in  = (x_in == FS) || (33'(p_in) == 33'(P_ONE));
  assign zero_in = !curve_mode && ((p_in == '0) || (ax_in == '0));

  logic          va;
  logic [SB-1:0] ma;
  logic [EB-1:0] pa;
  logic [SIDE-1:0] sa;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma <= curve_mode ? (FS - ax_in) : ax_in;
      pa <= p_in;
      sa <= {x_in, curve_mode, zero_in, byp_in, neg_in};
    end
  end

  // Log stages: -log2(m / FS) in Q.16.
  logic               vl;
  logic [LW-1:0]      ll;
  logic [SIDE+EB-1:0] sl;

  plw_log #(.SAMPLE_BITS(SB), .LW(LW), .SIDE_W(SIDE + EB)) u_log (
    .clk(clk), .rst(rst), .en(en), .vin(va), .mag(ma),
    .side_in({pa, sa}), .vout(vl), .neg_log(ll), .side_out(sl)
  );

  // Stage M: the complementary curve scales by p here; the root curve
  // hands L*256 to the divider.
  logic            vm;
  logic [QW-1:0]   nm;
  logic [EB-1:0]   pm;
  logic [EW-1:0]   em;
  logic [SIDE-1:0] sm;
  logic [MW-1:0]   prod_m;

  assign prod_m = MW'(ll) * MW'(sl[SIDE+EB-1:SIDE]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm <= {ll, 8'b0};
      pm <= sl[SIDE+EB-1:SIDE];
      em <= EW'(prod_m >> 8);
      sm <= sl[SIDE-1:0];
    end
  end

  // Divider stages: floor(L*256 / p) for the root curve.
  logic               vd;
  logic [QW-1:0]      qd;
  logic [SIDE+EW-1:0] sd;

  plw_div #(.QW(QW), .EXP_BITS(EB), .SIDE_W(SIDE + EW)) u_div (
    .clk(clk), .rst(rst), .en(en), .vin(vm), .num(nm), .den(pm),
    .side_in({em, sm}), .vout(vd), .quot(qd), .side_out(sd)
  );

  logic [EW-1:0] e_sel;
  assign e_sel = sd[3] ? sd[SIDE+EW-1:SIDE] : EW'(qd);

  // Exp stages: FS * 2^(-E), rounded half up.
  logic            vx;
  logic [SB-1:0]   rx;
  logic [SIDE-1:0] sx;

  plw_exp #(.SAMPLE_BITS(SB), .EW(EW), .SIDE_W(SIDE)) u_exp (
    .clk(clk), .rst(rst), .en(en), .vin(vd), .e(e_sel),
    .side_in(sd[SIDE-1:0]), .vout(vx), .r(rx), .side_out(sx)
  );

  // Final stage: apply curve, sign, special cases and saturation.
  logic [SB:0]   mag_f;
  logic [SB:0]   sv_f;
  logic [SB-1:0] v_f;

  always_comb begin
    mag_f = sx[3] ? ((SB+1)'(FS) - (SB+1)'(rx)) : (SB+1)'(rx);
    if (sx[2]) mag_f = '0;
    sv_f = (SB+1)'(-mag_f);
    if (sx[0]) begin
      v_f  = sv_f[SB-1:0];
    end else if (mag_f >= (SB+1)'(FS)) begin
      v_f = FS - SB'(1);
    end else begin
      v_f = mag_f[SB-1:0];
    end
    if (sx[1]) v_f = sx[SIDE-1:4];
  end

  logic [SB-1:0] out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sample <= v_f;
    end
  end

  assign m_axis_tdata = OW'(out_sample);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import plw_pkg::*;

  localparam int SB = 16;
  localparam int EB = 16;
  localparam int FS = 1 << (SB - 1);
  localparam int LATENCY = 37;
  localparam int LIMIT = 400000;
  localparam bit MODE_ROOT = 1'b0;
  localparam bit MODE_COMPL = 1'b1;

  typedef struct packed {
    logic [EB-1:0] p;
    logic signed [SB-1:0] x;
  } shaper_item_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_data = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  // sample_in [15:0], exponent [31:16]
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  // sample_out [15:0]
  logic [15:0] m_axis_tdata;

  power_law_waveshaper_top #(.SAMPLE_BITS(SB), .EXP_BITS(EB)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  shaper_item_t pending_samples[$];
  logic [SB-1:0] shaped_expected[$];
  bit shape_mode = MODE_ROOT;
  bit calm = 0;
  int mismatches = 0;
  longint cycles = 0;

  // -log2(m/FS) in Q.16 for m in [1, FS]
  function automatic longint unsigned neg_log2_q16(longint unsigned m);
    int top_bit;
    longint unsigned frac, lf;
    top_bit = 0;
    for (int b = 0; b < 63; b++) begin
      if (m[b]) top_bit = b;
    end
    if (top_bit >= 16) frac = (m >> (top_bit - 16)) & 64'hFFFF;
    else frac = (m << (16 - top_bit)) & 64'hFFFF;
    lf = frac + ((64'd22714 * frac * (64'd65536 - frac)) >> 32);
    if (top_bit > SB - 1) return 0;
    return longint'(SB - 1 - top_bit) * 65536 - lf;
  endfunction

  // FS * 2^(-e), rounded half up
  function automatic longint unsigned scaled_exp2(longint unsigned e);
    longint unsigned n, u, mant, prod, s;
    n = e >> 16;
    u = e & 64'hFFFF;
    mant = 65536 - (u >> 1) - ((64'd11246 * u * (64'd65536 - u)) >> 32);
    prod = mant << (SB - 1);
    if (n > 44) return 0;
    s = 16 + n;
    return (prod + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [SB-1:0] shape_sample(shaper_item_t it, bit mode);
    longint x, mag, v;
    longint unsigned ax, e, p;
    x = it.x;
    p = it.p;
    if (x == -FS || p == P_ONE) begin
      v = x;
    end else begin
      ax = (x < 0) ? -x : x;
      if (mode == MODE_ROOT) begin
        if (p == 0 || ax == 0) begin
          mag = 0;
        end else begin
          e = (neg_log2_q16(ax) << 8) / p;
          mag = scaled_exp2(e);
        end
      end else begin
        e = (neg_log2_q16(FS - ax) * p) >> 8;
        mag = FS - longint'(scaled_exp2(e));
      end
      v = (x < 0) ? -mag : mag;
    end
    if (v > FS - 1) v = FS - 1;
    if (v < -FS) v = -FS;
    return v[SB-1:0];
  endfunction

  function automatic shaper_item_t rand_item();
    shaper_item_t it;
    case ($urandom_range(0, 9))
      0: it.p = EB'(P_ONE);
      1: it.p = '0;
      2: it.p = EB'($urandom);
      default: it.p = EB'($urandom_range(1, 2048));
    endcase
    case ($urandom_range(0, 9))
      0: it.x = SB'(-FS);
      1: it.x = SB'(FS - 1);
      2: it.x = SB'($urandom_range(0, 3) - 2);
      default: it.x = SB'($urandom);
    endcase
    return it;
  endfunction

  // Driver: present the next pending sample, hold while the block stalls.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() > 0 && (calm || $urandom_range(0, 99) >= 21)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_samples[0];
          shaped_expected.push_back(shape_sample(pending_samples[0], shape_mode));
          void'(pending_samples.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  // Monitor: compare each output transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (shaped_expected.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected output %h", m_axis_tdata);
      end else begin
        if (m_axis_tdata !== shaped_expected[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("sample_out mismatch: expected %h got %h",
                     shaped_expected[0], m_axis_tdata);
        end
        void'(shaped_expected.pop_front());
      end
    end
  end

  // Stop the run on a hang.
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_samples.size() > 0 || s_axis_tvalid || shaped_expected.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_mode(bit mode);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= mode;
    shape_mode = mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_directed();
    shaper_item_t it;
    logic signed [SB-1:0] xs[8] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1,
                                    16'sd1, 16'sd16384, -16'sd16384, 16'sd12345};
    logic [EB-1:0] ps[4] = '{16'd0, 16'd256, 16'd512, 16'hFFFF};
    for (int i = 0; i < 8; i++) begin
      it.x = xs[i];
      it.p = ps[i % 4];
      pending_samples.push_back(it);
      it.p = ps[(i + 1) % 4];
      pending_samples.push_back(it);
    end
    it.x = 16'sh5555; it.p = 16'h5555; pending_samples.push_back(it);
    it.x = -16'sh5556; it.p = 16'hAAAA; pending_samples.push_back(it);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Directed sweep in both curve modes.
    load_directed();
    drain();
    write_mode(MODE_COMPL);
    load_directed();
    drain();
    // Random phases, alternating modes; one phase runs with no idling.
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0] ? MODE_ROOT : MODE_COMPL);
      calm = (ph == 3);
      for (int i = 0; i < 100; i++) pending_samples.push_back(rand_item());
      drain();
    end
    calm = 0;
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
